[src/sha1_hash_engine_assert.svh]
// Assertion macros for the SHA-1 engine checker.
// Depends on nothing; included by the checker file.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH
// Implication checked on every clock, off during reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked on every clock, off during reset.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[src/sha1_pkg.sv]
// Shared types, constants and round functions for the SHA-1 engine.
// No dependencies.
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int QDEPTH = 2;

	// Word handed from front to back: up to four bytes, last flag.
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  cnt;
		logic        last;
	} item_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) f = (b & c) ^ (~b & d);
		else if (r < 7'd40) f = b ^ c ^ d;
		else if (r < 7'd60) f = (b & c) ^ (b & d) ^ (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) k = K0;
		else if (r < 7'd40) k = K1;
		else if (r < 7'd60) k = K2;
		else k = K3;
		return k;
	endfunction
endpackage
`default_nettype wire

[src/sha1_hash_engine.sv]
// SHA-1 engine top level: front queue and back compression unit.
// Depends on sha1_pkg, sha1_front, sha1_back.
//  channel | signals                                   | role
//  in      | in_valid/in_ready, data_word, byte_count, last_word | message words
//  out     | out_valid/out_ready, digest_word, word_index, last_digest_word | digest
// A word leaves the queue in the idle state and is then packed byte by byte; a full block
// adds a load step and 80 rounds. Sustained throughput is set by the byte packer and the
// one-round unit; the back end takes no new word until it is idle again.
// A last word adds padding bytes, one or two blocks and five output words.
// Reset restores initial chaining values; no clearing pass.
// The two-entry queue keeps taking words while the back end compresses or stalls, until full.
`default_nettype none
module sha1_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_digest_word
);
	logic q_valid, q_pop;
	sha1_pkg::item_t q_item;

	// accept and queue words
	sha1_front u_front (.clk, .arst_n, .in_valid, .in_ready, .data_word, .byte_count,
		.last_word, .q_valid, .q_pop, .q_item);

	// pack, pad, compress and emit
	sha1_back u_back (.clk, .arst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_ready,
		.digest_word, .word_index, .last_digest_word);
endmodule
`default_nettype wire

[src/sha1_front.sv]
// Front end: accepts input words, clamps byte count, queues them.
// Depends on sha1_pkg.
`default_nettype none
module sha1_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [31:0]    data_word,
	input  wire logic [2:0]     byte_count,
	input  wire logic           last_word,
	output logic                q_valid,
	input  wire logic           q_pop,
	output sha1_pkg::item_t     q_item
);
	sha1_pkg::item_t mem_q [sha1_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = cnt_q != 2'(sha1_pkg::QDEPTH);
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q].data <= data_word;
			// clamp oversized counts
			mem_q[wp_q].cnt <= (byte_count > 3'd4) ? 3'd4 : byte_count;
			mem_q[wp_q].last <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

[src/sha1_back.sv]
// Back end: byte packing, padding, 80-round compression, digest output.
// Depends on sha1_pkg.
`default_nettype none
module sha1_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	output logic              q_pop,
	input  wire sha1_pkg::item_t q_item,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_digest_word
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_BYTE = 6'b000010,
		S_PAD  = 6'b000100,
		S_INIT = 6'b001000,
		S_RND  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t st_q;
	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [5:0]  fill_q;
	logic [60:0] mbytes_q;
	logic [6:0]  rnd_q;
	logic [31:0] data_q;
	logic [2:0]  left_q;
	logic        lenblk_q;
	logic        last_q, pad_q;
	logic [63:0] bits_q;
	logic [2:0]  oidx_q;

	logic [7:0]  cur_byte;
	logic [3:0]  widx, rix;
	logic [4:0]  sh;
	logic [31:0] wsch, wcur, tsum;

	assign q_pop = (st_q == S_IDLE) && q_valid;
	assign widx = fill_q[5:2];
	assign sh = {~fill_q[1:0], 3'b000};
	assign rix = rnd_q[3:0];
	assign wsch = sha1_pkg::rotl(w_q[rix + 4'd13] ^ w_q[rix + 4'd8] ^
		w_q[rix + 4'd2] ^ w_q[rix], 5'd1);
	assign wcur = (rnd_q < 7'd16) ? w_q[rix] : wsch;
	assign tsum = sha1_pkg::rotl(a_q, 5'd5) + sha1_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + sha1_pkg::round_k(rnd_q) + wcur;

	// byte to place this cycle: data, pad marker, zero or length
	always_comb begin
		cur_byte = data_q[31:24];
		if (st_q == S_PAD) begin
			if (!pad_q) cur_byte = sha1_pkg::PAD_BYTE;
			else if (lenblk_q && fill_q >= 6'd56) cur_byte = bits_q[63:56];
			else cur_byte = 8'h00;
		end
	end

	assign out_valid = st_q == S_OUT;
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_digest_word = oidx_q == 3'd4;

	always_ff @(posedge clk) begin
		if (st_q == S_BYTE || st_q == S_PAD)
			w_q[widx] <= (w_q[widx] & ~(32'hFF << sh)) | (32'(cur_byte) << sh);
		if (st_q == S_RND && rnd_q >= 7'd16) w_q[rix] <= wsch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			h_q <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
			fill_q <= '0; mbytes_q <= '0; rnd_q <= '0; oidx_q <= '0;
			data_q <= '0; left_q <= '0; lenblk_q <= 1'b0; last_q <= 1'b0; pad_q <= 1'b0;
			bits_q <= '0;
			{a_q, b_q, c_q, d_q, e_q} <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						data_q <= q_item.data;
						left_q <= q_item.cnt;
						last_q <= q_item.last;
						mbytes_q <= mbytes_q + 61'(q_item.cnt);
						st_q <= (q_item.cnt != 3'd0) ? S_BYTE
							: (q_item.last ? S_PAD : S_IDLE);
						pad_q <= 1'b0;
						bits_q <= {mbytes_q + 61'(q_item.cnt), 3'b000};
					end
				end
				S_BYTE: begin
					data_q <= data_q << 8;
					left_q <= left_q - 3'd1;
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) st_q <= S_INIT;
					else if (left_q == 3'd1) st_q <= last_q ? S_PAD : S_IDLE;
				end
				S_PAD: begin
					pad_q <= 1'b1;
					// the length goes in this block only if the marker leaves room
					if (!pad_q) lenblk_q <= fill_q < 6'd56;
					if (pad_q && lenblk_q && fill_q >= 6'd56) bits_q <= bits_q << 8;
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) st_q <= S_INIT;
				end
				S_INIT: begin
					{a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
					rnd_q <= '0;
					st_q <= S_RND;
				end
				S_RND: begin
					a_q <= tsum; b_q <= a_q; c_q <= sha1_pkg::rotl(b_q, 5'd30);
					d_q <= c_q; e_q <= d_q;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) begin
						h_q[0] <= h_q[0] + tsum; h_q[1] <= h_q[1] + a_q;
						h_q[2] <= h_q[2] + sha1_pkg::rotl(b_q, 5'd30);
						h_q[3] <= h_q[3] + c_q; h_q[4] <= h_q[4] + d_q;
						// resume: digest, next padding block, more data bytes or idle
						if (pad_q) begin
							if (lenblk_q) begin
								st_q <= S_OUT;
								oidx_q <= '0;
							end else begin
								lenblk_q <= 1'b1;
								st_q <= S_PAD;
							end
						end else if (left_q != 3'd0) st_q <= S_BYTE;
						else if (last_q) st_q <= S_PAD;
						else st_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd4) begin
							st_q <= S_IDLE;
							oidx_q <= '0;
							h_q <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2,
								sha1_pkg::H3, sha1_pkg::H4};
							mbytes_q <= '0;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[src/sha1_checker.sv]
// Port-level checker for the SHA-1 engine, bound to the top level.
// Depends on sha1_hash_engine_assert.svh.
`default_nettype none
`include "sha1_hash_engine_assert.svh"
module sha1_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  word_index,
	input wire logic        last_digest_word,
	input wire logic [31:0] digest_word
);
	logic out_stall, out_step;

	assign out_stall = out_valid && !out_ready;
	assign out_step = out_valid && out_ready && !last_digest_word;

	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, out_valid, last_digest_word == (word_index == 3'd4))
	`SHA_ASSERT_IMP(a_idx_rng, clk, arst_n, out_valid, word_index <= 3'd4)
	`SHA_ASSERT_NXT(a_hold, clk, arst_n, out_stall, out_valid && $stable(digest_word))
	`SHA_ASSERT_NXT(a_step, clk, arst_n, out_step, word_index == $past(word_index) + 3'd1)
endmodule
bind sha1_hash_engine sha1_checker u_chk (.clk, .arst_n, .out_valid, .out_ready,
	.word_index, .last_digest_word, .digest_word);
`default_nettype wire
